@@ rtl/core/q2e_pkg.sv @@
// Shared widths, status codes, angle table and arithmetic helpers for the quaternion-to-Euler core.
package q2e_pkg;

  localparam int unsigned CORDIC_ITER_DEF = 16;
  localparam int unsigned ATAN_LEN        = 24;

  // Width of the q30 product terms after the shift by 30.
  localparam int unsigned TW   = 34;
  // Width of the CORDIC vector lanes.
  localparam int unsigned CW   = 40;
  // Width of the angle accumulator, 1/65536 degree.
  localparam int unsigned ZW   = 26;
  // Square root: result bits and remainder width.
  localparam int unsigned SQ_W = 31;
  localparam int unsigned RW   = 62;

  localparam logic signed [CW-1:0] Q_ONE     = CW'(64'd1 << 30);
  localparam logic signed [ZW-1:0] ANG_P90   = ZW'(5898240);
  localparam logic signed [ZW-1:0] ANG_N90   = -ANG_P90;
  localparam logic [15:0]          PITCH_LIM = 16'd11520;
  localparam logic [15:0]          ANG_LIM   = 16'd23040;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_READ_FAIL = 2'd1,
    STATUS_NO_QUAT   = 2'd2
  } status_e;

  // Data that rides alongside the square-root cells.
  typedef struct packed {
    status_e                status;
    logic signed [31:0]     s;
    logic signed [CW-1:0]   roll_y;
    logic signed [CW-1:0]   roll_x;
    logic signed [CW-1:0]   yaw_y;
    logic signed [CW-1:0]   yaw_x;
  } side_t;

  // atan(2^-i) in 1/65536 degree, rounded to nearest.
  function automatic int atan_lut(input int unsigned idx);
    int v;
    case (idx)
      0:       v = 2949120;
      1:       v = 1740967;
      2:       v = 919879;
      3:       v = 466945;
      4:       v = 234379;
      5:       v = 117304;
      6:       v = 58666;
      7:       v = 29335;
      8:       v = 14668;
      9:       v = 7334;
      10:      v = 3667;
      11:      v = 1833;
      12:      v = 917;
      13:      v = 458;
      14:      v = 229;
      15:      v = 115;
      16:      v = 57;
      17:      v = 29;
      18:      v = 14;
      19:      v = 7;
      20:      v = 4;
      21:      v = 2;
      22:      v = 1;
      default: v = 0;
    endcase
    return v;
  endfunction

  // Divide a q60 product by 2^30, truncating toward zero.
  function automatic logic signed [TW-1:0] q30_trunc(input logic signed [63:0] p);
    logic signed [63:0] bias;
    logic signed [63:0] sh;
    bias = p[63] ? 64'sd1073741823 : 64'sd0;
    sh   = (p + bias) >>> 30;
    return sh[TW-1:0];
  endfunction

  // Round 1/65536 degree to 1/128 degree, half away from zero, and clamp.
  function automatic logic signed [15:0] round_angle(input logic signed [ZW-1:0] z,
                                                     input logic [15:0] lim);
    logic [ZW-1:0] mag;
    logic [ZW-1:0] r;
    logic [15:0]   rs;
    mag = z[ZW-1] ? ZW'(-z) : ZW'(z);
    r   = (mag + ZW'(256)) >> 9;
    rs  = (r > ZW'(lim)) ? lim : r[15:0];
    return z[ZW-1] ? -$signed(rs) : $signed(rs);
  endfunction

endpackage

@@ rtl/core/quaternion_to_euler_angles.sv @@
// Top level: quaternion to Z-Y-X Euler angles in 1/128 degree, fully pipelined.
//
//  channel  dir  tdata                                      tuser
//  s_axis   in   [31:0] w, [63:32] x, [95:64] y, [127:96] z [0] read_failed, [1] has_quaternion
//  m_axis   out  [14:0] pitch, [30:15] roll, [46:31] yaw    [1:0] status
//
// One request per cycle sustained while the output is taken. The stages, in order:
// products, term truncation, sums, square, radicand, 31 square-root cells,
// pre-rotation, one cell per CORDIC iteration and the output register.
// Reset clears the valid line and the output valid; data registers are not reset
// and there is no clearing pass.
// The pipeline stalls as a whole only when its last stage holds a result and
// the output register is full and not taken.
module quaternion_to_euler_angles #(
  parameter int unsigned CORDIC_ITERATIONS = q2e_pkg::CORDIC_ITER_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [127:0] s_axis_tdata_i,  // quat_w, quat_x, quat_y, quat_z
  input  logic [1:0]   s_axis_tuser_i,  // read_failed, has_quaternion
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  output logic [47:0]  m_axis_tdata_o,  // pitch_angle, roll_angle, yaw_angle, zero pad
  output logic [1:0]   m_axis_tuser_o   // status
);

  localparam int unsigned N      = CORDIC_ITERATIONS;
  localparam int unsigned SQ_W   = q2e_pkg::SQ_W;
  localparam int unsigned CW     = q2e_pkg::CW;
  localparam int unsigned ZW     = q2e_pkg::ZW;
  localparam int unsigned TW     = q2e_pkg::TW;
  localparam int unsigned RW     = q2e_pkg::RW;
  localparam int unsigned NV     = 5 + SQ_W + 1 + N;
  localparam int unsigned SD_N   = 3 + SQ_W;

  logic          en;
  logic [NV-1:0] vld_q;

  // ---------------- stage 1: products ----------------
  logic signed [31:0] qw, qx, qy, qz;
  logic signed [63:0] p_ww_q, p_xx_q, p_yy_q, p_zz_q, p_wy_q;
  logic signed [63:0] p_xz_q, p_yz_q, p_wx_q, p_xy_q, p_wz_q;
  q2e_pkg::status_e   st1_d, st1_q, st2_q;

  assign qw = s_axis_tdata_i[31:0];
  assign qx = s_axis_tdata_i[63:32];
  assign qy = s_axis_tdata_i[95:64];
  assign qz = s_axis_tdata_i[127:96];

  always_comb begin
    if (s_axis_tuser_i[0]) begin
      st1_d = q2e_pkg::STATUS_READ_FAIL;
    end else if (!s_axis_tuser_i[1]) begin
      st1_d = q2e_pkg::STATUS_NO_QUAT;
    end else begin
      st1_d = q2e_pkg::STATUS_OK;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p_ww_q <= qw * qw;
      p_xx_q <= qx * qx;
      p_yy_q <= qy * qy;
      p_zz_q <= qz * qz;
      p_wy_q <= qw * qy;
      p_xz_q <= qx * qz;
      p_yz_q <= qy * qz;
      p_wx_q <= qw * qx;
      p_xy_q <= qx * qy;
      p_wz_q <= qw * qz;
      st1_q  <= st1_d;
    end
  end

  // ---------------- stage 2: q30 terms ----------------
  logic signed [TW-1:0] t_ww_q, t_xx_q, t_yy_q, t_zz_q, t_wy_q;
  logic signed [TW-1:0] t_xz_q, t_yz_q, t_wx_q, t_xy_q, t_wz_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      t_ww_q <= q2e_pkg::q30_trunc(p_ww_q);
      t_xx_q <= q2e_pkg::q30_trunc(p_xx_q);
      t_yy_q <= q2e_pkg::q30_trunc(p_yy_q);
      t_zz_q <= q2e_pkg::q30_trunc(p_zz_q);
      t_wy_q <= q2e_pkg::q30_trunc(p_wy_q);
      t_xz_q <= q2e_pkg::q30_trunc(p_xz_q);
      t_yz_q <= q2e_pkg::q30_trunc(p_yz_q);
      t_wx_q <= q2e_pkg::q30_trunc(p_wx_q);
      t_xy_q <= q2e_pkg::q30_trunc(p_xy_q);
      t_wz_q <= q2e_pkg::q30_trunc(p_wz_q);
      st2_q  <= st1_q;
    end
  end

  // ---------------- stage 3: sums and saturation ----------------
  q2e_pkg::side_t       sd_q [0:SD_N-1];
  q2e_pkg::side_t       sd3_d;
  logic signed [CW-1:0] s_wide;

  always_comb begin
    s_wide = (CW'(t_wy_q) - CW'(t_xz_q)) <<< 1;
    sd3_d.status = st2_q;
    if (s_wide > q2e_pkg::Q_ONE) begin
      sd3_d.s = q2e_pkg::Q_ONE[31:0];
    end else if (s_wide < -q2e_pkg::Q_ONE) begin
      sd3_d.s = -q2e_pkg::Q_ONE[31:0];
    end else begin
      sd3_d.s = s_wide[31:0];
    end
    sd3_d.roll_y = (CW'(t_yz_q) + CW'(t_wx_q)) <<< 1;
    sd3_d.roll_x = q2e_pkg::Q_ONE - ((CW'(t_xx_q) + CW'(t_yy_q)) <<< 1);
    sd3_d.yaw_y  = (CW'(t_xy_q) + CW'(t_wz_q)) <<< 1;
    sd3_d.yaw_x  = CW'(t_ww_q) + CW'(t_xx_q) - CW'(t_yy_q) - CW'(t_zz_q);
  end

  // ---------------- stages 4, 5: radicand ----------------
  logic signed [63:0] s_sq;
  logic [RW-1:0]      sq_q, rad_q;

  assign s_sq = sd_q[0].s * sd_q[0].s;

  always_ff @(posedge clk_i) begin
    if (en) begin
      sd_q[0] <= sd3_d;
      sd_q[1] <= sd_q[0];
      sd_q[2] <= sd_q[1];
      for (int k = 3; k < SD_N; k++) begin
        sd_q[k] <= sd_q[k-1];
      end
      sq_q  <= s_sq[RW-1:0];
      rad_q <= (RW'(1) << 60) - sq_q;
    end
  end

  // ---------------- square-root cells ----------------
  logic [RW-1:0]   rem_a  [1:SQ_W];
  logic [SQ_W-1:0] root_a [1:SQ_W];

  for (genvar j = 0; j < SQ_W; j++) begin : g_sqrt
    logic [RW-1:0]   rem_in;
    logic [SQ_W-1:0] root_in;
    if (j == 0) begin : g_first
      assign rem_in  = rad_q;
      assign root_in = '0;
    end else begin : g_next
      assign rem_in  = rem_a[j];
      assign root_in = root_a[j];
    end
    q2e_sqrt_cell #(
      .BIT (SQ_W - 1 - j)
    ) u_cell (
      .clk_i  (clk_i),
      .en_i   (en),
      .rem_i  (rem_in),
      .root_i (root_in),
      .rem_o  (rem_a[j+1]),
      .root_o (root_a[j+1])
    );
  end

  // ---------------- pre-rotation (lanes: pitch, roll, yaw) ----------------
  logic signed [CW-1:0] lx [0:2];
  logic signed [CW-1:0] ly [0:2];
  logic signed [CW-1:0] px_d [0:2];
  logic signed [CW-1:0] py_d [0:2];
  logic signed [ZW-1:0] pz_d [0:2];
  logic [2:0]           zf_d;
  logic signed [CW-1:0] px_q [0:2];
  logic signed [CW-1:0] py_q [0:2];
  logic signed [ZW-1:0] pz_q [0:2];
  logic [2:0]           zf_q [0:N];
  q2e_pkg::status_e     cst_q [0:N];

  always_comb begin
    lx[0] = CW'(root_a[SQ_W]);
    ly[0] = CW'(sd_q[SD_N-1].s);
    lx[1] = sd_q[SD_N-1].roll_x;
    ly[1] = sd_q[SD_N-1].roll_y;
    lx[2] = sd_q[SD_N-1].yaw_x;
    ly[2] = sd_q[SD_N-1].yaw_y;
    for (int l = 0; l < 3; l++) begin
      zf_d[l] = (lx[l] == '0) && (ly[l] == '0);
      if (lx[l][CW-1]) begin
        if (!ly[l][CW-1]) begin
          px_d[l] = ly[l];
          py_d[l] = -lx[l];
          pz_d[l] = q2e_pkg::ANG_P90;
        end else begin
          px_d[l] = -ly[l];
          py_d[l] = lx[l];
          pz_d[l] = q2e_pkg::ANG_N90;
        end
      end else begin
        px_d[l] = lx[l];
        py_d[l] = ly[l];
        pz_d[l] = '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int l = 0; l < 3; l++) begin
        px_q[l] <= px_d[l];
        py_q[l] <= py_d[l];
        pz_q[l] <= pz_d[l];
      end
      zf_q[0]  <= zf_d;
      cst_q[0] <= sd_q[SD_N-1].status;
      for (int k = 1; k <= N; k++) begin
        zf_q[k]  <= zf_q[k-1];
        cst_q[k] <= cst_q[k-1];
      end
    end
  end

  // ---------------- CORDIC cells ----------------
  logic signed [CW-1:0] cx [1:N][0:2];
  logic signed [CW-1:0] cy [1:N][0:2];
  logic signed [ZW-1:0] cz [1:N][0:2];

  for (genvar i = 0; i < N; i++) begin : g_iter
    for (genvar l = 0; l < 3; l++) begin : g_lane
      logic signed [CW-1:0] x_in, y_in;
      logic signed [ZW-1:0] z_in;
      if (i == 0) begin : g_first
        assign x_in = px_q[l];
        assign y_in = py_q[l];
        assign z_in = pz_q[l];
      end else begin : g_next
        assign x_in = cx[i][l];
        assign y_in = cy[i][l];
        assign z_in = cz[i][l];
      end
      q2e_cordic_cell #(
        .SHIFT (i)
      ) u_cell (
        .clk_i (clk_i),
        .en_i  (en),
        .x_i   (x_in),
        .y_i   (y_in),
        .z_i   (z_in),
        .x_o   (cx[i+1][l]),
        .y_o   (cy[i+1][l]),
        .z_o   (cz[i+1][l])
      );
    end
  end

  // ---------------- rounding and output register ----------------
  logic signed [15:0] pitch_r, roll_r, yaw_r;
  logic               zero_out;
  logic [47:0]        tdata_d;
  logic [47:0]        tdata_q;
  logic [1:0]         tuser_q;
  logic               tvalid_q;

  always_comb begin
    zero_out = (cst_q[N] != q2e_pkg::STATUS_OK);
    pitch_r  = q2e_pkg::round_angle(cz[N][0], q2e_pkg::PITCH_LIM);
    roll_r   = q2e_pkg::round_angle(cz[N][1], q2e_pkg::ANG_LIM);
    yaw_r    = q2e_pkg::round_angle(cz[N][2], q2e_pkg::ANG_LIM);
    if (zero_out || zf_q[N][0]) pitch_r = '0;
    if (zero_out || zf_q[N][1]) roll_r  = '0;
    if (zero_out || zf_q[N][2]) yaw_r   = '0;
    tdata_d = {1'b0, yaw_r, roll_r, pitch_r[14:0]};
  end

  // Advance unless a finished result would overrun a stalled output register.
  assign en = !vld_q[NV-1] || !tvalid_q || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      tvalid_q <= 1'b0;
    end else begin
      if (en) begin
        vld_q <= {vld_q[NV-2:0], s_axis_tvalid_i};
      end
      if (en && vld_q[NV-1]) begin
        tvalid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        tvalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && vld_q[NV-1]) begin
      tdata_q <= tdata_d;
      tuser_q <= cst_q[N];
    end
  end

  assign s_axis_tready_o = en;
  assign m_axis_tvalid_o = tvalid_q;
  assign m_axis_tdata_o  = tdata_q;
  assign m_axis_tuser_o  = tuser_q;

`ifndef ASSERT_OFF
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o |-> s_axis_tready_o)
    else $error("input stalled while output register empty");

  a_error_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o != q2e_pkg::STATUS_OK) |-> (m_axis_tdata_o == '0))
    else $error("nonzero angles on error status");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tuser_o == q2e_pkg::STATUS_OK ||
                         m_axis_tuser_o == q2e_pkg::STATUS_READ_FAIL ||
                         m_axis_tuser_o == q2e_pkg::STATUS_NO_QUAT))
    else $error("undefined status code");

  a_load_on_tail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tready_o && vld_q[NV-1]) |=> m_axis_tvalid_o)
    else $error("finished result not loaded");
`endif

endmodule

@@ rtl/core/q2e_sqrt_cell.sv @@
// One result bit of the pipelined integer square root.
module q2e_sqrt_cell #(
  parameter int unsigned BIT = 0
) (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [q2e_pkg::RW-1:0]      rem_i,
  input  logic [q2e_pkg::SQ_W-1:0]    root_i,
  output logic [q2e_pkg::RW-1:0]      rem_o,
  output logic [q2e_pkg::SQ_W-1:0]    root_o
);

  logic [q2e_pkg::RW-1:0] cand;

  // Only root bits above BIT are set, so the two terms never overlap.
  assign cand = (q2e_pkg::RW'(root_i) << (BIT + 1)) | (q2e_pkg::RW'(1) << (2 * BIT));

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (rem_i >= cand) begin
        rem_o  <= rem_i - cand;
        root_o <= root_i | (q2e_pkg::SQ_W'(1) << BIT);
      end else begin
        rem_o  <= rem_i;
        root_o <= root_i;
      end
    end
  end

endmodule

@@ rtl/core/q2e_cordic_cell.sv @@
// One vectoring micro-rotation of the CORDIC chain.
module q2e_cordic_cell #(
  parameter int unsigned SHIFT = 0
) (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  logic signed [q2e_pkg::CW-1:0]     x_i,
  input  logic signed [q2e_pkg::CW-1:0]     y_i,
  input  logic signed [q2e_pkg::ZW-1:0]     z_i,
  output logic signed [q2e_pkg::CW-1:0]     x_o,
  output logic signed [q2e_pkg::CW-1:0]     y_o,
  output logic signed [q2e_pkg::ZW-1:0]     z_o
);

  localparam logic signed [q2e_pkg::ZW-1:0] ATAN =
    q2e_pkg::ZW'(q2e_pkg::atan_lut(SHIFT));
  localparam logic signed [q2e_pkg::CW-1:0] RND =
    q2e_pkg::CW'((64'd1 << SHIFT) - 64'd1);

  logic signed [q2e_pkg::CW-1:0] xb, yb, xs, ys;

  // Shift toward zero: bias negative values before the arithmetic shift.
  always_comb begin
    xb = x_i[q2e_pkg::CW-1] ? RND : q2e_pkg::CW'(0);
    yb = y_i[q2e_pkg::CW-1] ? RND : q2e_pkg::CW'(0);
    xs = (x_i + xb) >>> SHIFT;
    ys = (y_i + yb) >>> SHIFT;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (!y_i[q2e_pkg::CW-1]) begin
        x_o <= x_i + ys;
        y_o <= y_i - xs;
        z_o <= z_i + ATAN;
      end else begin
        x_o <= x_i - ys;
        y_o <= y_i + xs;
        z_o <= z_i - ATAN;
      end
    end
  end

endmodule

@@ verif/tb_quaternion_to_euler_angles.sv @@
// Testbench for the quaternion to Euler angle pipeline: directed table, random stream, predictor.
module tb_quaternion_to_euler_angles;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ITERS     = 16;
  localparam int unsigned LATENCY   = 38 + ITERS;
  localparam int unsigned N_RANDOM  = 750;
  localparam int unsigned WATCHDOG  = 2000;
  localparam int unsigned HOLD_LEN  = 300;

  typedef struct packed {
    logic        read_failed;
    logic        has_quat;
    logic [31:0] qw;
    logic [31:0] qx;
    logic [31:0] qy;
    logic [31:0] qz;
  } quat_req_t;

  typedef struct packed {
    q2e_pkg::status_e   status;
    logic signed [14:0] pitch;
    logic signed [15:0] roll;
    logic signed [15:0] yaw;
  } euler_t;

  typedef struct {
    quat_req_t req;
    logic      known;  // expected angles typed in the table
    euler_t    angles;
  } stim_row_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid_i = 1'b0;
  logic         s_axis_tready_o;
  logic [127:0] s_axis_tdata_i = '0;
  logic [1:0]   s_axis_tuser_i = '0;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i = 1'b0;
  logic [47:0]  m_axis_tdata_o;
  logic [1:0]   m_axis_tuser_o;

  euler_t expected_angles[$];
  int     n_errors = 0;
  int     idle_cycles = 0;
  int     rx_idle = 0;
  bit     no_gaps = 1'b0;
  bit     hold_off = 1'b0;
  bit     timed_out = 1'b0;

  always #6 clk_i = ~clk_i;

  quaternion_to_euler_angles #(.CORDIC_ITERATIONS(ITERS)) DUT (.*);

  // ---------------------------------------------------------------- predictor
  function automatic longint q30_mul(longint a, longint b);
    return (a * b) / (longint'(1) << 30);
  endfunction

  function automatic longint int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return longint'(r);
  endfunction

  function automatic longint angle_of(longint y, longint x, longint lim);
    longint ang, t, xs, ys, mag, r;
    longint steps[24] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
                          29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115,
                          57, 29, 14, 7, 4, 2, 1, 0};
    ang = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y; y = -t; ang = 90 * 65536;
      end else begin
        x = -y; y = t; ang = -90 * 65536;
      end
    end
    for (int i = 0; i < ITERS && i < 24; i++) begin
      xs = x / (longint'(1) << i);
      ys = y / (longint'(1) << i);
      if (y >= 0) begin
        x += ys; y -= xs; ang += steps[i];
      end else begin
        x -= ys; y += xs; ang -= steps[i];
      end
    end
    mag = ang < 0 ? -ang : ang;
    r = (mag + 256) / 512;
    if (r > lim) r = lim;
    return ang < 0 ? -r : r;
  endfunction

  function automatic euler_t euler_from_quat(quat_req_t q);
    euler_t e;
    longint w, x, y, z, s, c, one;
    e = '0;
    one = longint'(1) << 30;
    if (q.read_failed) begin
      e.status = q2e_pkg::STATUS_READ_FAIL;
    end else if (!q.has_quat) begin
      e.status = q2e_pkg::STATUS_NO_QUAT;
    end else begin
      w = longint'($signed(q.qw));
      x = longint'($signed(q.qx));
      y = longint'($signed(q.qy));
      z = longint'($signed(q.qz));
      s = 2 * (q30_mul(w, y) - q30_mul(x, z));
      if (s > one) s = one;
      if (s < -one) s = -one;
      c = int_sqrt(longint'(one * one - s * s));
      e.status = q2e_pkg::STATUS_OK;
      e.pitch = 15'(angle_of(s, c, 11520));
      e.roll  = 16'(angle_of(2 * (q30_mul(y, z) + q30_mul(w, x)),
                             one - 2 * (q30_mul(x, x) + q30_mul(y, y)), 23040));
      e.yaw   = 16'(angle_of(2 * (q30_mul(x, y) + q30_mul(w, z)),
                             q30_mul(w, w) + q30_mul(x, x) - q30_mul(y, y)
                             - q30_mul(z, z), 23040));
    end
    return e;
  endfunction

  // ---------------------------------------------------------------- stimulus
  function automatic quat_req_t make_req(bit rf, bit hq, int w, int x, int y, int z);
    quat_req_t q;
    q.read_failed = rf; q.has_quat = hq;
    q.qw = w; q.qx = x; q.qy = y; q.qz = z;
    return q;
  endfunction

  function automatic quat_req_t random_req();
    quat_req_t q;
    int unsigned pick;
    q = make_req(1'b0, 1'b1, $urandom, $urandom, $urandom, $urandom);
    pick = $urandom_range(0, 19);
    if (pick == 0) q.read_failed = 1'b1;
    else if (pick == 1) q.has_quat = 1'b0;
    else if (pick == 2) q.read_failed = $urandom_range(0, 1);
    else if (pick < 16) begin
      // bounded quaternion: each component within about +-1.0 in q30
      q.qw = $urandom_range(0, 32'h8000_0000) - 32'h4000_0000;
      q.qx = $urandom_range(0, 32'h8000_0000) - 32'h4000_0000;
      q.qy = $urandom_range(0, 32'h8000_0000) - 32'h4000_0000;
      q.qz = $urandom_range(0, 32'h8000_0000) - 32'h4000_0000;
    end else if (pick < 18) begin
      q.qw = $signed(q.qw) >>> $urandom_range(0, 31);
      q.qx = $signed(q.qx) >>> $urandom_range(0, 31);
      q.qy = $signed(q.qy) >>> $urandom_range(0, 31);
      q.qz = $signed(q.qz) >>> $urandom_range(0, 31);
    end
    return q;
  endfunction

  // Hold valid after the accept; drop it only for an idle burst.
  task automatic send(quat_req_t q);
    if (!no_gaps && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {q.qz, q.qy, q.qx, q.qw};
    s_axis_tuser_i  <= {q.has_quat, q.read_failed};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------- receiver
  always @(posedge clk_i) begin
    if (!rst_ni || hold_off) begin
      m_axis_tready_i <= 1'b0;
      rx_idle <= 0;
    end else if (no_gaps) begin
      m_axis_tready_i <= 1'b1;
      rx_idle <= 0;
    end else if (rx_idle > 1) begin
      m_axis_tready_i <= 1'b0;
      rx_idle <= rx_idle - 1;
    end else if (rx_idle == 1) begin
      m_axis_tready_i <= 1'b1;
      rx_idle <= 0;
    end else if ($urandom_range(0, 7) == 0) begin
      m_axis_tready_i <= 1'b0;
      rx_idle <= $urandom_range(1, 11);
    end else begin
      m_axis_tready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    euler_t got, want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got = {q2e_pkg::status_e'(m_axis_tuser_o), m_axis_tdata_o[14:0],
             m_axis_tdata_o[30:15], m_axis_tdata_o[46:31]};
      if (expected_angles.size() == 0) begin
        $error("result with no request pending");
        n_errors++;
      end else begin
        want = expected_angles.pop_front();
        if (got.status !== want.status) begin
          $error("status expected %0d actual %0d", want.status, got.status); n_errors++;
        end
        if (got.pitch !== want.pitch) begin
          $error("pitch_angle expected %0d actual %0d", want.pitch, got.pitch); n_errors++;
        end
        if (got.roll !== want.roll) begin
          $error("roll_angle expected %0d actual %0d", want.roll, got.roll); n_errors++;
        end
        if (got.yaw !== want.yaw) begin
          $error("yaw_angle expected %0d actual %0d", want.yaw, got.yaw); n_errors++;
        end
      end
    end
  end

  // predict on every accepted request
  always @(posedge clk_i) begin
    quat_req_t q;
    if (rst_ni && s_axis_tvalid_i && s_axis_tready_o) begin
      q = make_req(s_axis_tuser_i[0], s_axis_tuser_i[1], s_axis_tdata_i[31:0],
                   s_axis_tdata_i[63:32], s_axis_tdata_i[95:64], s_axis_tdata_i[127:96]);
      expected_angles.push_back(euler_from_quat(q));
    end
  end

  // watchdog: cycles with no transfer on either side
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
      idle_cycles <= 0;
    else if (rst_ni)
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG && !timed_out) begin
      timed_out <= 1'b1;
      $display("FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------- main
  initial begin
    stim_row_t rows[$];
    localparam int ONE = 32'h4000_0000;
    localparam int S45 = 759250125;  // sin(45 deg) in q30
    rows = '{
      '{make_req(1, 1, ONE, 0, 0, 0), 1'b1,
        '{q2e_pkg::STATUS_READ_FAIL, 15'sd0, 16'sd0, 16'sd0}},
      '{make_req(1, 0, -1, -1, -1, -1), 1'b1,
        '{q2e_pkg::STATUS_READ_FAIL, 15'sd0, 16'sd0, 16'sd0}},
      '{make_req(0, 0, ONE, ONE, ONE, ONE), 1'b1,
        '{q2e_pkg::STATUS_NO_QUAT, 15'sd0, 16'sd0, 16'sd0}},
      '{make_req(0, 1, ONE, 0, 0, 0), 1'b1,
        '{q2e_pkg::STATUS_OK, 15'sd0, 16'sd0, 16'sd0}},
      '{make_req(0, 1, 0, 0, 0, 0), 1'b0, '0},
      '{make_req(0, 1, S45, 0, S45, 0), 1'b0, '0},
      '{make_req(0, 1, S45, 0, -S45, 0), 1'b0, '0},
      '{make_req(0, 1, S45, S45, 0, 0), 1'b0, '0},
      '{make_req(0, 1, S45, 0, 0, S45), 1'b0, '0},
      '{make_req(0, 1, 0, ONE, 0, 0), 1'b0, '0},
      '{make_req(0, 1, 0, 0, 0, ONE), 1'b0, '0},
      '{make_req(0, 1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF), 1'b0, '0},
      '{make_req(0, 1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000), 1'b0, '0},
      '{make_req(0, 1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000), 1'b0, '0},
      '{make_req(0, 1, ONE, 0, ONE, 0), 1'b0, '0},
      '{make_req(0, 1, ONE, 0, -ONE, 0), 1'b0, '0},
      '{make_req(0, 1, -ONE, 1, -1, 0), 1'b0, '0},
      '{make_req(0, 1, 1, 0, 0, 0), 1'b0, '0},
      '{make_req(0, 1, -1, -1, -1, -1), 1'b0, '0}
    };
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) begin
      send(rows[i].req);
      if (rows[i].known && euler_from_quat(rows[i].req) !== rows[i].angles) begin
        $error("table row %0d disagrees with the predictor", i);
        n_errors++;
      end
    end

    // long receiver hold while requests keep coming, so the pipeline backs up
    fork
      begin
        hold_off <= 1'b1;
        repeat (HOLD_LEN) @(posedge clk_i);
        hold_off <= 1'b0;
      end
      for (int i = 0; i < 120; i++) send(random_req());
    join

    for (int i = 0; i < N_RANDOM - 120; i++) begin
      if (i == N_RANDOM - 220) no_gaps = 1'b1;
      send(random_req());
    end
    s_axis_tvalid_i <= 1'b0;

    while (expected_angles.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
    if (n_errors == 0 && expected_angles.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
